>>> rtl/bpmc_pkg.sv
// Shared types and constants for the button press mode control block.
package bpmc_pkg;

  localparam int unsigned DEB_W  = 10;
  localparam int unsigned TICK_W = 16;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RST   = 10'd50;
  localparam logic [TICK_W-1:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [TICK_W-1:0] INTERVAL_RST   = 16'd5000;

  // Display mode in which a long press toggles mute.
  localparam logic [MODE_W-1:0] MUTE_MODE = 2'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE   = 2'd0,
    CFG_LONG_PRESS = 2'd1,
    CFG_INTERVAL   = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    EV_NONE          = 3'd0,
    EV_MODE_ADVANCED = 3'd1,
    EV_MUTE_TOGGLED  = 3'd2,
    EV_LONG_IGNORED  = 3'd3,
    EV_ALARM_STOP    = 3'd4
  } button_event_t;

  typedef struct packed {
    logic button_level;
    logic alarm_ringing;
    logic auto_enable_request;
  } bpmc_in_t;

  typedef struct packed {
    logic [MODE_W-1:0] display_mode;
    logic              auto_mode;
    logic              muted;
    button_event_t     button_event;
    logic              auto_advanced;
    logic              debounced_level;
  } bpmc_out_t;

endpackage

>>> rtl/button_press_mode_control.sv
// Button press mode control: debouncer, press classifier and display mode rotation.
//
// Usage: each input transaction on in_* is one millisecond tick carrying the
// raw active-low button level, the alarm-ringing flag and an auto rotation
// enable request. Every accepted tick produces exactly one result transaction
// on out_* with the display mode, auto and mute flags, the button event and
// the debounced level after that tick.
// Registers are written through cfg_* (index 0 debounce ticks, 1 long press
// ticks, 2 mode interval ticks); cfg_ready is always high, writes to index 3
// are dropped. Write them only while no tick is in flight.
// A tick's result is registered and shown on out_* in the cycle after its
// acceptance. Throughput is one tick per cycle while results are taken; all
// state is updated by a single pass of counter, compare and mode increment
// logic at acceptance. The result register holds one transaction; when the
// receiver stalls, in_ready drops until that result is taken, so nothing is lost.
// Reset (rst_n low, synchronous) restores the default registers, releases
// the debouncer, selects mode 0 with auto rotation on and mute off, and
// empties the result register.
module button_press_mode_control
  import bpmc_pkg::*;
#(
  parameter int unsigned MODE_COUNT = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bpmc_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bpmc_out_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [MODE_W-1:0] LAST_MODE = MODE_W'(MODE_COUNT - 1);
  localparam logic [DEB_W-1:0]  DEB_MAX   = '1;
  localparam logic [TICK_W-1:0] TICK_MAX  = '1;

  logic [DEB_W-1:0]  debounce_r;
  logic [TICK_W-1:0] long_press_r;
  logic [TICK_W-1:0] interval_r;

  logic              prev_raw_r, prev_raw_nxt;
  logic              stable_r, stable_nxt;
  logic [DEB_W-1:0]  tsc_r, tsc_nxt;
  logic              pending_r, pending_nxt;
  logic [TICK_W-1:0] press_r, press_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic              auto_en_r, auto_en_nxt;
  logic              mute_r, mute_nxt;
  logic [TICK_W-1:0] tsa_r, tsa_nxt;
  logic              out_valid_r;
  bpmc_out_t         out_data_r, out_data_nxt;

  logic              in_fire;
  logic [MODE_W-1:0] mode_btn;
  logic              auto_btn;
  logic              advanced;
  button_event_t     event_c;

  function automatic logic [MODE_W-1:0] next_mode(input logic [MODE_W-1:0] m);
    next_mode = (m == LAST_MODE) ? '0 : m + MODE_W'(1);
  endfunction

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    tsc_nxt      = (tsc_r == DEB_MAX) ? tsc_r : tsc_r + DEB_W'(1);
    press_nxt    = (pending_r && press_r != TICK_MAX) ? press_r + TICK_W'(1) : press_r;
    tsa_nxt      = (tsa_r == TICK_MAX) ? tsa_r : tsa_r + TICK_W'(1);
    prev_raw_nxt = in_data.button_level;
    stable_nxt   = stable_r;
    pending_nxt  = pending_r;
    mute_nxt     = mute_r;
    mode_btn     = mode_r;
    auto_btn     = auto_en_r;
    event_c      = EV_NONE;
    advanced     = 1'b0;

    if (in_data.button_level != prev_raw_r) begin
      tsc_nxt = '0;
    end
    if (in_data.auto_enable_request) begin
      auto_btn = 1'b1;
      tsa_nxt  = '0;
    end

    if (tsc_nxt > debounce_r && in_data.button_level != stable_r) begin
      stable_nxt = in_data.button_level;
      if (!in_data.button_level) begin
        press_nxt   = '0;
        pending_nxt = 1'b1;
      end else if (pending_r) begin
        pending_nxt = 1'b0;
        priority if (in_data.alarm_ringing) begin
          event_c = EV_ALARM_STOP;
        end else if (press_nxt < long_press_r) begin
          mode_btn = next_mode(mode_r);
          auto_btn = 1'b0;
          event_c  = EV_MODE_ADVANCED;
        end else if (mode_r == MUTE_MODE) begin
          mute_nxt = !mute_r;
          event_c  = EV_MUTE_TOGGLED;
        end else begin
          event_c = EV_LONG_IGNORED;
        end
      end
    end

    mode_nxt    = mode_btn;
    auto_en_nxt = auto_btn;
    // Auto rotation runs after the button so a short press can cancel it.
    if (auto_btn && tsa_nxt >= interval_r) begin
      tsa_nxt  = '0;
      mode_nxt = next_mode(mode_btn);
      advanced = 1'b1;
    end

    out_data_nxt.display_mode    = mode_nxt;
    out_data_nxt.auto_mode       = auto_en_nxt;
    out_data_nxt.muted           = mute_nxt;
    out_data_nxt.button_event    = event_c;
    out_data_nxt.auto_advanced   = advanced;
    out_data_nxt.debounced_level = stable_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      long_press_r <= LONG_PRESS_RST;
      interval_r   <= INTERVAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEBOUNCE:   debounce_r   <= cfg_wdata[DEB_W-1:0];
        CFG_LONG_PRESS: long_press_r <= cfg_wdata[TICK_W-1:0];
        CFG_INTERVAL:   interval_r   <= cfg_wdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_raw_r  <= 1'b1;
      stable_r    <= 1'b1;
      tsc_r       <= '0;
      pending_r   <= 1'b0;
      press_r     <= '0;
      mode_r      <= '0;
      auto_en_r   <= 1'b1;
      mute_r      <= 1'b0;
      tsa_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        prev_raw_r <= prev_raw_nxt;
        stable_r   <= stable_nxt;
        tsc_r      <= tsc_nxt;
        pending_r  <= pending_nxt;
        press_r    <= press_nxt;
        mode_r     <= mode_nxt;
        auto_en_r  <= auto_en_nxt;
        mute_r     <= mute_nxt;
        tsa_r      <= tsa_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

>>> rtl/bpmc_checker.sv
// Port-level checker for button_press_mode_control and its bind statement.
module bpmc_checker
  import bpmc_pkg::*;
#(
  parameter int unsigned MODE_COUNT = 3
) (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input bpmc_out_t out_data
);

  localparam logic [MODE_W-1:0] LAST_MODE = MODE_W'(MODE_COUNT - 1);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.display_mode <= LAST_MODE)
    else $error("display mode out of range");

  a_short_stops_auto: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.button_event == EV_MODE_ADVANCED
      |-> !out_data.auto_mode && !out_data.auto_advanced)
    else $error("auto rotation active after a short press");

  a_adv_needs_auto: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.auto_advanced |-> out_data.auto_mode)
    else $error("auto advance while auto rotation is off");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind button_press_mode_control bpmc_checker #(.MODE_COUNT(MODE_COUNT)) u_bpmc_checker (.*);

>>> verif/testbench.sv
// Self-checking testbench for the button press mode control block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bpmc_pkg::*;

  localparam int MODES = 3;
  localparam int QUIET_LIMIT = 2000;
  localparam int PRINT_LIMIT = 100;
  // The register index that the block has no register behind.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  bpmc_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  bpmc_out_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  button_press_mode_control dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Register copies as the block should hold them.
  logic [DEB_W-1:0]  debounce_limit = DEBOUNCE_RST;
  logic [TICK_W-1:0] long_press_limit = LONG_PRESS_RST;
  logic [TICK_W-1:0] rotate_interval = INTERVAL_RST;

  // Controller state as the block should hold it.
  logic              last_raw = 1'b1;
  logic              accepted_level = 1'b1;
  logic [DEB_W-1:0]  stable_count = '0;
  logic              press_open = 1'b0;
  logic [TICK_W-1:0] press_length = '0;
  logic [MODE_W-1:0] mode_now = '0;
  logic              rotate_on = 1'b1;
  logic              mute_on = 1'b0;
  logic [TICK_W-1:0] rotate_count = '0;

  bpmc_out_t expected_displays[$];
  int        error_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_off = 0;
  int        quiet_cycles = 0;

  function automatic logic [MODE_W-1:0] following_mode(input logic [MODE_W-1:0] m);
    return (m == MODE_W'(MODES - 1)) ? '0 : m + MODE_W'(1);
  endfunction

  // Advances the expected controller state by one tick and returns its display.
  function automatic bpmc_out_t predict_display(input bpmc_in_t t);
    button_event_t ev;
    logic          advanced;
    bpmc_out_t     r;
    ev = EV_NONE;
    advanced = 1'b0;
    if (stable_count != '1) stable_count++;
    if (press_open && press_length != '1) press_length++;
    if (rotate_count != '1) rotate_count++;
    if (t.button_level != last_raw) stable_count = '0;
    if (t.auto_enable_request) begin
      rotate_on = 1'b1;
      rotate_count = '0;
    end
    if (stable_count > debounce_limit && t.button_level != accepted_level) begin
      accepted_level = t.button_level;
      if (!accepted_level) begin
        press_length = '0;
        press_open = 1'b1;
      end else if (press_open) begin
        press_open = 1'b0;
        if (t.alarm_ringing) begin
          ev = EV_ALARM_STOP;
        end else if (press_length < long_press_limit) begin
          mode_now = following_mode(mode_now);
          rotate_on = 1'b0;
          ev = EV_MODE_ADVANCED;
        end else if (mode_now == MUTE_MODE) begin
          mute_on = ~mute_on;
          ev = EV_MUTE_TOGGLED;
        end else begin
          ev = EV_LONG_IGNORED;
        end
      end
    end
    last_raw = t.button_level;
    // A short press has already cleared rotate_on, so it never rotates here.
    if (rotate_on && rotate_count >= rotate_interval) begin
      rotate_count = '0;
      mode_now = following_mode(mode_now);
      advanced = 1'b1;
    end
    r.display_mode = mode_now;
    r.auto_mode = rotate_on;
    r.muted = mute_on;
    r.button_event = ev;
    r.auto_advanced = advanced;
    r.debounced_level = accepted_level;
    return r;
  endfunction

  task automatic report_error(input string msg);
    if (error_count < PRINT_LIMIT) $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_display(input bpmc_out_t got);
    bpmc_out_t want;
    if (expected_displays.size() == 0) begin
      report_error("result transaction with no tick outstanding");
      return;
    end
    want = expected_displays.pop_front();
    if (got.display_mode !== want.display_mode)
      report_error($sformatf("display_mode %0d, expected %0d",
                             got.display_mode, want.display_mode));
    if (got.auto_mode !== want.auto_mode)
      report_error($sformatf("auto_mode %0d, expected %0d", got.auto_mode, want.auto_mode));
    if (got.muted !== want.muted)
      report_error($sformatf("muted %0d, expected %0d", got.muted, want.muted));
    if (got.button_event !== want.button_event)
      report_error($sformatf("button_event %0d, expected %0d",
                             got.button_event, want.button_event));
    if (got.auto_advanced !== want.auto_advanced)
      report_error($sformatf("auto_advanced %0d, expected %0d",
                             got.auto_advanced, want.auto_advanced));
    if (got.debounced_level !== want.debounced_level)
      report_error($sformatf("debounced_level %0d, expected %0d",
                             got.debounced_level, want.debounced_level));
  endtask

  // Receiver: checks each result, then picks out_ready for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_display(out_data);
    if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[button_press_mode_control] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Leaves cfg_valid high so that back-to-back writes need no lowering.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_DEBOUNCE:   debounce_limit = data[DEB_W-1:0];
      CFG_LONG_PRESS: long_press_limit = data;
      CFG_INTERVAL:   rotate_interval = data;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [DEB_W-1:0] deb, input logic [TICK_W-1:0] lng,
                           input logic [TICK_W-1:0] ivl);
    logic [CFG_DATA_W-DEB_W-1:0] upper;
    logic [CFG_DATA_W-1:0]       junk;
    upper = (CFG_DATA_W-DEB_W)'($urandom);
    junk = CFG_DATA_W'($urandom);
    // The bits above the debounce field carry random values and must be dropped.
    write_register(CFG_DEBOUNCE, {upper, deb});
    write_register(CFG_LONG_PRESS, lng);
    write_register(CFG_INTERVAL, ivl);
    write_register(CFG_SPARE, junk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_tick(input logic lvl, input logic ring, input logic req);
    bpmc_in_t t;
    t.button_level = lvl;
    t.alarm_ringing = ring;
    t.auto_enable_request = req;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_data <= t;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_displays.push_back(predict_display(t));
  endtask

  task automatic hold_level(input logic lvl, input int n, input logic ring, input logic req);
    for (int i = 0; i < n; i++) send_tick(lvl, ring, req);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_displays.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Reset registers: one press long enough to pass a debounce of 50.
  task automatic test_reset_defaults();
    hold_level(1'b0, 55, 1'b0, 1'b0);
    hold_level(1'b1, 55, 1'b0, 1'b0);
    drain();
  endtask

  // Short press, mute toggle, ignored long press and alarm stop.
  task automatic test_press_kinds();
    configure(10'd0, 16'd3, 16'd65535);
    hold_level(1'b0, 5, 1'b0, 1'b0);
    hold_level(1'b1, 2, 1'b0, 1'b0);
    hold_level(1'b0, 2, 1'b0, 1'b0);
    hold_level(1'b1, 2, 1'b0, 1'b0);
    hold_level(1'b0, 5, 1'b0, 1'b0);
    hold_level(1'b1, 2, 1'b0, 1'b0);
    hold_level(1'b0, 2, 1'b0, 1'b0);
    hold_level(1'b1, 2, 1'b1, 1'b0);
    drain();
  endtask

  // Largest debounce accepts nothing; the long stable count then passes a small one.
  task automatic test_debounce_limits();
    configure(10'd1023, 16'd0, 16'd65535);
    hold_level(1'b0, 60, 1'b0, 1'b0);
    drain();
    configure(10'd2, 16'd0, 16'd65535);
    hold_level(1'b0, 3, 1'b0, 1'b0);
    hold_level(1'b1, 4, 1'b0, 1'b0);
    drain();
    configure(10'd0, 16'd0, 16'd65535);
    for (int i = 0; i < 8; i++) send_tick(i[0], 1'b0, 1'b0);
    hold_level(1'b1, 3, 1'b0, 1'b0);
    drain();
  endtask

  task automatic test_auto_rotation();
    configure(10'd0, 16'd4, 16'd0);
    hold_level(1'b1, 1, 1'b0, 1'b1);
    hold_level(1'b1, 3, 1'b0, 1'b0);
    // A long press release lands on a tick that also rotates.
    hold_level(1'b0, 6, 1'b0, 1'b0);
    hold_level(1'b1, 2, 1'b0, 1'b0);
    hold_level(1'b0, 2, 1'b0, 1'b0);
    hold_level(1'b1, 3, 1'b0, 1'b0);
    drain();
    configure(10'd1, 16'd4, 16'd3);
    hold_level(1'b1, 1, 1'b0, 1'b1);
    hold_level(1'b1, 10, 1'b0, 1'b0);
    drain();
  endtask

  // Largest press and rotation limits: every press is short and nothing rotates.
  task automatic test_large_limits();
    configure(10'd0, 16'd65535, 16'd65535);
    hold_level(1'b0, 2, 1'b0, 1'b0);
    hold_level(1'b1, 2, 1'b0, 1'b0);
    hold_level(1'b0, 20, 1'b0, 1'b0);
    hold_level(1'b1, 3, 1'b0, 1'b0);
    hold_level(1'b1, 1, 1'b0, 1'b1);
    hold_level(1'b1, 20, 1'b0, 1'b0);
    drain();
  endtask

  // The receiver stops for a long stretch while ticks keep coming.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    configure(10'd1, 16'd5, 16'd7);
    hold_off = 300;
    for (int i = 0; i < 40; i++)
      send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom_range(7) == 0);
    drain();
  endtask

  task automatic test_random_presses(input int items, input int idle_pct, input int stall_pct);
    int         sent;
    int         run;
    int         deb_eff;
    logic       ring;
    logic [9:0] deb;
    logic [15:0] lng;
    logic [15:0] ivl;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    deb = ($urandom_range(19) == 0) ? DEB_W'($urandom_range(1023))
                                    : DEB_W'($urandom_range(3));
    lng = ($urandom_range(9) == 0) ? TICK_W'($urandom_range(65535))
                                   : TICK_W'($urandom_range(8));
    ivl = ($urandom_range(4) == 0) ? TICK_W'($urandom_range(65535))
                                   : TICK_W'($urandom_range(30));
    configure(deb, lng, ivl);
    deb_eff = (debounce_limit > 20) ? 20 : debounce_limit;
    sent = 0;
    while (sent < items) begin
      // Mostly presses that clear the debouncer, now and then a one-tick glitch.
      run = ($urandom_range(6) == 0) ? 1 : deb_eff + 1 + $urandom_range(10);
      for (int i = 0; i < run; i++)
        send_tick(1'b0, 1'($urandom_range(1)), $urandom_range(15) == 0);
      sent += run;
      ring = ($urandom_range(3) == 0);
      run = ($urandom_range(6) == 0) ? 1 : deb_eff + 1 + $urandom_range(6);
      for (int i = 0; i < run; i++)
        send_tick(1'b1, ring, $urandom_range(15) == 0);
      sent += run;
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_press_kinds();
    test_debounce_limits();
    test_auto_rotation();
    test_large_limits();
    test_backpressure();
    test_random_presses(45, 0, 0);
    test_random_presses(45, 77, 0);
    test_random_presses(45, 0, 77);
    test_random_presses(45, 23, 23);
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("[button_press_mode_control] OK");
    end else begin
      $display("[button_press_mode_control] ERROR");
    end
    $finish;
  end

endmodule
